// ===== hdl/tcgp_pkg.sv =====
// Shared types and constants for the text cursor glyph placer.
// Holds command kinds, character codes, configuration layout and queue sizing.
// No dependencies.
`default_nettype none

package tcgp_pkg;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_HEIGHT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_OFFSET   = 3'd6;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_REGION_X      = 16'd0;
    localparam logic [15:0] RST_REGION_Y      = 16'd0;
    localparam logic [14:0] RST_REGION_WIDTH  = 15'd320;
    localparam logic [14:0] RST_REGION_HEIGHT = 15'd240;
    localparam logic [7:0]  RST_CHAR_WIDTH    = 8'd6;
    localparam logic [7:0]  RST_CHAR_HEIGHT   = 8'd8;
    localparam logic [7:0]  RST_CODE_OFFSET   = 8'd32;

    // Input operations
    localparam logic OP_PUT    = 1'b0;
    localparam logic OP_SETLOC = 1'b1;

    // Control characters
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_BS  = 8'h08;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;

    // Tab stops every eight columns: bump the column in bits [7:3]
    localparam int unsigned TAB_SHIFT = 3;

    // Command kinds passed from front to back
    typedef logic [2:0] t_kind;
    localparam t_kind K_PUT    = 3'd0;
    localparam t_kind K_SETLOC = 3'd1;
    localparam t_kind K_CR     = 3'd2;
    localparam t_kind K_LF     = 3'd3;
    localparam t_kind K_TAB    = 3'd4;
    localparam t_kind K_BS     = 3'd5;

    typedef struct packed {
        logic [15:0] region_x;
        logic [15:0] region_y;
        logic [14:0] region_width;
        logic [14:0] region_height;
        logic [7:0]  char_width;
        logic [7:0]  char_height;
        logic [7:0]  code_offset;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  code;
        logic [7:0]  new_row;
        logic [7:0]  new_col;
        logic [15:0] glyph_row;
    } t_cmd;

    // Head of the command queue as seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

    // Command queue sizing
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

endpackage

`default_nettype wire

// ===== hdl/tcgp_if.sv =====
// Valid/ready channel interfaces for the text cursor glyph placer.
// tcgp_char_if carries input requests, tcgp_draw_if carries draw commands.
// No dependencies.
`default_nettype none

interface tcgp_char_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] char_code;
    logic [7:0] new_row;
    logic [7:0] new_col;

    modport source (output valid, output operation, output char_code,
                    output new_row, output new_col, input ready);
    modport sink   (input valid, input operation, input char_code,
                    input new_row, input new_col, output ready);
endinterface

interface tcgp_draw_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [7:0]         glyph_code;
    logic signed [15:0] glyph_row;

    modport source (output valid, output pixel_x, output pixel_y,
                    output glyph_code, output glyph_row, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y,
                    input glyph_code, input glyph_row, output ready);
endinterface

`default_nettype wire

// ===== hdl/text_cursor_glyph_placer_unit.sv =====
// Channel   | Dir | Transfer carries
// i_char    | in  | operation, char_code, new_row, new_col
// o_draw    | out | pixel_x, pixel_y, glyph_code, glyph_row
// i_cfg_*   | in  | register index and write data, no handshake
//
// One request per cycle sustained while the draw output is not stalled; a draw
// command is held in the queue and then in the output register before it leaves.
// The cursor update in the back end is a registered loop around one column and one row multiplier.
// Synchronous active-low reset clears the cursor, queue and output valid and
// loads the register defaults. A stalled draw output backs up into the
// two-entry queue; non-drawing commands keep executing while a draw waits.
//
// Top level of the text cursor glyph placer: configuration registers and
// front/queue/back wiring. Depends on tcgp_pkg, tcgp_if and the tcgp_* modules.
`default_nettype none

module text_cursor_glyph_placer_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    tcgp_char_if.sink                            i_char,
    tcgp_draw_if.source                          o_draw,
    input  logic                                 i_cfg_we,
    input  logic [tcgp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tcgp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import tcgp_pkg::*;

    t_cfg  r_cfg;
    t_cmd  s_cmd;
    t_head s_head;
    logic  s_push, s_pop, s_full;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.region_x      <= RST_REGION_X;
            r_cfg.region_y      <= RST_REGION_Y;
            r_cfg.region_width  <= RST_REGION_WIDTH;
            r_cfg.region_height <= RST_REGION_HEIGHT;
            r_cfg.char_width    <= RST_CHAR_WIDTH;
            r_cfg.char_height   <= RST_CHAR_HEIGHT;
            r_cfg.code_offset   <= RST_CODE_OFFSET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REGION_X:      r_cfg.region_x      <= i_cfg_data;
                CFG_REGION_Y:      r_cfg.region_y      <= i_cfg_data;
                CFG_REGION_WIDTH:  r_cfg.region_width  <= i_cfg_data[14:0];
                CFG_REGION_HEIGHT: r_cfg.region_height <= i_cfg_data[14:0];
                CFG_CHAR_WIDTH:    r_cfg.char_width    <= i_cfg_data[7:0];
                CFG_CHAR_HEIGHT:   r_cfg.char_height   <= i_cfg_data[7:0];
                CFG_CODE_OFFSET:   r_cfg.code_offset   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    tcgp_front u_front (
        .i_char   (i_char),
        .i_cfg    (r_cfg),
        .i_q_full (s_full),
        .o_push   (s_push),
        .o_cmd    (s_cmd)
    );

    tcgp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_cmd   (s_cmd),
        .i_pop   (s_pop),
        .o_full  (s_full),
        .o_head  (s_head)
    );

    tcgp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (s_head),
        .o_pop   (s_pop),
        .o_draw  (o_draw)
    );

`ifndef SYNTHESIS
    // Out of reset: nothing to draw and room for a request
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_draw.valid && i_char.ready)
        else $error("not idle after reset");

    // Back pressure on requests only when the queue holds commands
    a_stall_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_char.ready |-> s_head.valid)
        else $error("request stalled with empty queue");

    // A new draw command comes only from a popped put command
    a_draw_from_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_draw.valid) |-> $past(s_pop && s_head.cmd.kind == K_PUT))
        else $error("draw output without a put command");
`endif

endmodule

`default_nettype wire

// ===== hdl/tcgp_front.sv =====
// Front end: accepts requests, classifies them and computes the glyph row offset.
// Depends on tcgp_pkg and tcgp_char_if.
`default_nettype none

module tcgp_front (
    tcgp_char_if.sink        i_char,
    input  tcgp_pkg::t_cfg   i_cfg,
    input  logic             i_q_full,
    output logic             o_push,
    output tcgp_pkg::t_cmd   o_cmd
);
    import tcgp_pkg::*;

    logic        s_drop;
    logic [15:0] s_code_diff;

    // Take a request whenever the queue has room
    assign i_char.ready = !i_q_full;

    // NUL bytes in put requests are swallowed here and never reach the back end
    assign s_drop = (i_char.operation == OP_PUT) && (i_char.char_code == CHAR_NUL);
    assign o_push = i_char.valid && !i_q_full && !s_drop;

    // Classify the request
    always_comb begin
        if (i_char.operation == OP_SETLOC) begin
            o_cmd.kind = K_SETLOC;
        end else begin
            case (i_char.char_code)
                CHAR_CR:  o_cmd.kind = K_CR;
                CHAR_LF:  o_cmd.kind = K_LF;
                CHAR_TAB: o_cmd.kind = K_TAB;
                CHAR_BS:  o_cmd.kind = K_BS;
                default:  o_cmd.kind = K_PUT;
            endcase
        end
    end

    // Glyph row in the font bitmap, two's complement wrap at 16 bits
    assign s_code_diff = {8'd0, i_char.char_code} - {8'd0, i_cfg.code_offset};
    assign o_cmd.glyph_row = 16'(s_code_diff * {8'd0, i_cfg.char_height});

    assign o_cmd.code    = i_char.char_code;
    assign o_cmd.new_row = i_char.new_row;
    assign o_cmd.new_col = i_char.new_col;

endmodule

`default_nettype wire

// ===== hdl/tcgp_queue.sv =====
// Two-entry command queue between the front and back ends.
// Depends on tcgp_pkg.
`default_nettype none

module tcgp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tcgp_pkg::t_cmd   i_cmd,
    input  logic             i_pop,
    output logic             o_full,
    output tcgp_pkg::t_head  o_head
);
    import tcgp_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count,  n_count;

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_full       = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

// ===== hdl/tcgp_back.sv =====
// Back end: holds the cursor, executes commands and registers draw commands.
// Depends on tcgp_pkg and tcgp_draw_if.
`default_nettype none

module tcgp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tcgp_pkg::t_cfg   i_cfg,
    input  tcgp_pkg::t_head  i_head,
    output logic             o_pop,
    tcgp_draw_if.source      o_draw
);
    import tcgp_pkg::*;

    logic [7:0]  r_col, n_col;
    logic [7:0]  r_row, n_row;
    logic        r_out_valid;
    logic [15:0] r_px, r_py, r_gr;
    logic [7:0]  r_code;

    logic [7:0]  s_tab_col, s_col_op, s_row_op, s_inc_col, s_inc_row;
    logic [15:0] s_col_prod, s_row_prod;
    logic [16:0] s_inc_col_prod, s_inc_row_prod;
    logic        s_col_past, s_inc_col_past, s_inc_row_past;
    logic        s_put;

    // A draw needs the output register free or draining this cycle
    assign s_put = (i_head.cmd.kind == K_PUT);
    assign o_pop = i_head.valid && (!s_put || !r_out_valid || o_draw.ready);

    // Next tab stop
    assign s_tab_col = {r_col[7:TAB_SHIFT] + 1'b1, {TAB_SHIFT{1'b0}}};

    // Operand select: one column and one row multiplier serve all commands
    always_comb begin
        case (i_head.cmd.kind)
            K_SETLOC: s_col_op = i_head.cmd.new_col;
            K_TAB:    s_col_op = s_tab_col;
            default:  s_col_op = r_col;
        endcase
    end
    assign s_row_op = (i_head.cmd.kind == K_SETLOC) ? i_head.cmd.new_row : r_row;

    assign s_col_prod = {8'd0, s_col_op} * {8'd0, i_cfg.char_width};
    assign s_row_prod = {8'd0, s_row_op} * {8'd0, i_cfg.char_height};

    // Products of the incremented counters, zero when the counter wraps
    assign s_inc_col = s_col_op + 1'b1;
    assign s_inc_row = s_row_op + 1'b1;
    assign s_inc_col_prod = (s_col_op == 8'hFF) ? 17'd0
                          : {1'b0, s_col_prod} + {9'd0, i_cfg.char_width};
    assign s_inc_row_prod = (s_row_op == 8'hFF) ? 17'd0
                          : {1'b0, s_row_prod} + {9'd0, i_cfg.char_height};

    // Wrap tests at full precision
    assign s_col_past     = s_col_prod >= {1'b0, i_cfg.region_width};
    assign s_inc_col_past = s_inc_col_prod >= {2'b0, i_cfg.region_width};
    assign s_inc_row_past = s_inc_row_prod >= {2'b0, i_cfg.region_height};

    // Cursor update
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        case (i_head.cmd.kind)
            K_PUT: begin
                if (s_inc_col_past) begin
                    n_col = '0;
                    n_row = s_inc_row_past ? 8'd0 : s_inc_row;
                end else begin
                    n_col = s_inc_col;
                end
            end
            K_SETLOC: begin
                if (s_col_past) begin
                    n_col = '0;
                    n_row = s_inc_row_past ? 8'd0 : s_inc_row;
                end else begin
                    n_col = i_head.cmd.new_col;
                    n_row = i_head.cmd.new_row;
                end
            end
            K_TAB: begin
                // no height check on a tab wrap
                if (s_col_past) begin
                    n_col = '0;
                    n_row = s_inc_row;
                end else begin
                    n_col = s_tab_col;
                end
            end
            K_LF: begin
                n_col = '0;
                n_row = s_inc_row;
            end
            K_CR: begin
                n_col = '0;
            end
            K_BS: begin
                if (r_col != 8'd0) begin
                    n_col = r_col - 1'b1;
                end
            end
            default: begin
                n_col = r_col;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_pop) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && s_put) begin
            r_out_valid <= 1'b1;
        end else if (o_draw.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && s_put) begin
            r_px   <= i_cfg.region_x + s_col_prod;
            r_py   <= i_cfg.region_y + s_row_prod;
            r_code <= i_head.cmd.code;
            r_gr   <= i_head.cmd.glyph_row;
        end
    end

    assign o_draw.valid      = r_out_valid;
    assign o_draw.pixel_x    = $signed(r_px);
    assign o_draw.pixel_y    = $signed(r_py);
    assign o_draw.glyph_code = r_code;
    assign o_draw.glyph_row  = $signed(r_gr);

endmodule

`default_nettype wire
